// ===== design/bfmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_pkg
// Shared types and constants of the byte frequency model builder.
// ----------------------------------------------------------------------------
package bfmb_pkg;

   localparam int SYMBOLS_DEF = 256;
   localparam int FREQS_DEF   = 8;
   localparam int MAX_SLOTS   = 8;
   localparam int FREQ_W      = 32;
   localparam int PROD_W      = 64;
   localparam int GRP_OUT_W   = 5;
   localparam int CSR_AW      = 2;

   localparam logic [CSR_AW-1:0] ADDR_TARGET_TOTAL = CSR_AW'(0);
   localparam logic [FREQ_W-1:0] TARGET_TOTAL_RST  = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_SCL_RD,
      ST_SCL_MUL,
      ST_SCL_DIV,
      ST_FIX,
      ST_EM_RD,
      ST_EM_CAP
   } state_type;

   typedef struct packed {
      logic                start;
      logic [PROD_W-1:0]   dividend;
      logic [FREQ_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [FREQ_W-1:0]   quotient;
   } div_rsp_type;

endpackage

// ===== design/bfmb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle. Quotient low 32 bits are returned with a done pulse.
// ----------------------------------------------------------------------------
module bfmb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bfmb_pkg::div_req_type req,
   output bfmb_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(bfmb_pkg::PROD_W);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [bfmb_pkg::FREQ_W-1:0]  rem_ff, rem_in;
   logic [bfmb_pkg::PROD_W-1:0]  dvd_ff, dvd_in;
   logic [bfmb_pkg::FREQ_W-1:0]  dsr_ff, dsr_in;
   logic [bfmb_pkg::FREQ_W:0]    trial;
   logic [bfmb_pkg::FREQ_W:0]    diff;
   logic                         qbit;

   always_comb begin
      trial  = {rem_ff, dvd_ff[bfmb_pkg::PROD_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      qbit   = (trial >= {1'b0, dsr_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         dvd_in = req.dividend;
         dsr_in = req.divisor;
      end else if (run_ff) begin
         // shift one dividend bit in, subtract when it fits
         rem_in = qbit ? diff[bfmb_pkg::FREQ_W-1:0] : trial[bfmb_pkg::FREQ_W-1:0];
         dvd_in = {dvd_ff[bfmb_pkg::PROD_W-2:0], qbit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(bfmb_pkg::PROD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff[bfmb_pkg::FREQ_W-1:0];

endmodule

// ===== design/byte_frequency_model_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_frequency_model_builder_core
// Order-0 byte histogram that scales to a target total and emits the table.
// ----------------------------------------------------------------------------
// Each byte passes accept, bin read and bin write-back. A byte marked
// last then scales every bin: per bin a read, one 32x32 multiply and a
// 64-step pass of the shared divider, then one correction write and the
// table readout, a bin read and a capture per symbol. Busy stays high
// all that time. Each group word appears on the rsp_ ports for a single
// cycle with rsp_strobe; the receiver cannot stall, so it must take every word.
// ----------------------------------------------------------------------------
module byte_frequency_model_builder_core #(
   parameter int SYMBOLS          = bfmb_pkg::SYMBOLS_DEF,
   parameter int FREQS_PER_RESULT = bfmb_pkg::FREQS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_strobe,
   output logic [bfmb_pkg::GRP_OUT_W-1:0] rsp_group_index,
   output logic [31:0]                   rsp_freq_a,
   output logic [31:0]                   rsp_freq_b,
   output logic [31:0]                   rsp_freq_c,
   output logic [31:0]                   rsp_freq_d,
   output logic [31:0]                   rsp_freq_e,
   output logic [31:0]                   rsp_freq_f,
   output logic [31:0]                   rsp_freq_g,
   output logic [31:0]                   rsp_freq_h,
   output logic                          rsp_last_group,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bfmb_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int SYM_AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int SUM_W      = bfmb_pkg::FREQ_W + SYM_AW;
   localparam int NUM_GROUPS = (SYMBOLS + FREQS_PER_RESULT - 1) / FREQS_PER_RESULT;
   localparam int GRP_W      = $clog2(NUM_GROUPS + 1);
   localparam int FW         = bfmb_pkg::FREQ_W;

   bfmb_pkg::state_type state_ff, state_in;

   logic [FW-1:0]       mem [SYMBOLS];
   logic [SYMBOLS-1:0]  vld_ff, vld_in;
   logic [FW-1:0]       rd_data_ff;
   logic                rd_vld_ff;
   logic [SYM_AW-1:0]   rd_addr;
   logic                wr_en;
   logic [SYM_AW-1:0]   wr_addr;
   logic [FW-1:0]       wr_data;
   logic [FW-1:0]       rd_value;

   logic [FW-1:0]       total_ff, total_in;
   logic [FW-1:0]       seen_ff, seen_in;
   logic [SYM_AW-1:0]   sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [SYM_AW-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [FW-1:0]       top_val_ff, top_val_in;
   logic [SYM_AW-1:0]   top_idx_ff, top_idx_in;
   logic [bfmb_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [2:0]          slot_ff, slot_in;
   logic [FW-1:0]       slots_ff [bfmb_pkg::MAX_SLOTS];
   logic [FW-1:0]       slots_in [bfmb_pkg::MAX_SLOTS];
   logic [GRP_W-1:0]    grp_ff, grp_in;
   logic [31:0]         grp_ext;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [bfmb_pkg::GRP_OUT_W-1:0] rsp_grp_ff, rsp_grp_in;
   logic [FW-1:0]       rsp_freq_ff [bfmb_pkg::MAX_SLOTS];
   logic [FW-1:0]       rsp_freq_in [bfmb_pkg::MAX_SLOTS];
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                in_alpha;
   logic                commit;
   logic [FW-1:0]       scaled;
   logic                csr_wr;

   bfmb_pkg::div_req_type div_req;
   bfmb_pkg::div_rsp_type div_rsp;

   bfmb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept   = start && (state_ff == bfmb_pkg::ST_IDLE);
   assign in_alpha = (9'(req_data_byte) < 9'(SYMBOLS));
   assign rd_value = rd_vld_ff ? rd_data_ff : '0;
   assign csr_wr   = psel && penable && pwrite && (paddr == bfmb_pkg::ADDR_TARGET_TOTAL);
   assign grp_ext  = 32'(grp_ff);

   always_comb begin
      state_in   = state_ff;
      vld_in     = vld_ff;
      seen_in    = seen_ff;
      sym_in     = sym_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      top_val_in = top_val_ff;
      top_idx_in = top_idx_ff;
      prod_in    = prod_ff;
      slot_in    = slot_ff;
      grp_in     = grp_ff;
      for (int k = 0; k < bfmb_pkg::MAX_SLOTS; k++) begin
         slots_in[k]    = slots_ff[k];
         rsp_freq_in[k] = rsp_freq_ff[k];
      end
      rsp_strobe_in = 1'b0;
      rsp_grp_in    = rsp_grp_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      commit        = 1'b0;
      scaled        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = seen_ff;
      total_in = csr_wr ? pwdata : total_ff;

      unique case (state_ff)
         bfmb_pkg::ST_IDLE: begin
            if (accept) begin
               sym_in  = req_data_byte[SYM_AW-1:0];
               last_in = req_last_byte;
               idx_in  = '0;
               sum_in  = '0;
               top_val_in = '0;
               top_idx_in = '0;
               if (in_alpha) begin
                  if (seen_ff != '1) seen_in = seen_ff + FW'(1);
                  state_in = bfmb_pkg::ST_CNT_RD;
               end else if (req_last_byte) begin
                  state_in = bfmb_pkg::ST_SCL_RD;
               end
            end
         end
         bfmb_pkg::ST_CNT_RD: begin
            rd_addr  = sym_ff;
            state_in = bfmb_pkg::ST_CNT_WR;
         end
         bfmb_pkg::ST_CNT_WR: begin
            wr_en   = 1'b1;
            wr_addr = sym_ff;
            wr_data = (rd_value == '1) ? rd_value : rd_value + FW'(1);
            vld_in[sym_ff] = 1'b1;
            state_in = last_ff ? bfmb_pkg::ST_SCL_RD : bfmb_pkg::ST_IDLE;
         end
         bfmb_pkg::ST_SCL_RD: begin
            state_in = bfmb_pkg::ST_SCL_MUL;
         end
         bfmb_pkg::ST_SCL_MUL: begin
            prod_in = bfmb_pkg::PROD_W'(rd_value) * bfmb_pkg::PROD_W'(total_ff);
            if (seen_ff == '0) begin
               // empty text: every bin scales to zero
               commit = 1'b1;
            end else begin
               state_in = bfmb_pkg::ST_SCL_DIV;
            end
         end
         bfmb_pkg::ST_SCL_DIV: begin
            if (div_rsp.done) begin
               commit = 1'b1;
               scaled = div_rsp.quotient;
            end
         end
         bfmb_pkg::ST_FIX: begin
            // one write covers add and subtract: wraps modulo 2^32
            wr_en   = 1'b1;
            wr_addr = top_idx_ff;
            wr_data = top_val_ff + total_ff - sum_ff[FW-1:0];
            vld_in[top_idx_ff] = 1'b1;
            idx_in  = '0;
            slot_in = '0;
            grp_in  = '0;
            for (int k = 0; k < bfmb_pkg::MAX_SLOTS; k++) slots_in[k] = '0;
            state_in = bfmb_pkg::ST_EM_RD;
         end
         bfmb_pkg::ST_EM_RD: begin
            state_in = bfmb_pkg::ST_EM_CAP;
         end
         bfmb_pkg::ST_EM_CAP: begin
            slots_in[slot_ff] = rd_value;
            if ((slot_ff == 3'(FREQS_PER_RESULT - 1)) ||
                (idx_ff == SYM_AW'(SYMBOLS - 1))) begin
               rsp_strobe_in = 1'b1;
               rsp_grp_in    = grp_ext[bfmb_pkg::GRP_OUT_W-1:0];
               rsp_last_in   = (idx_ff == SYM_AW'(SYMBOLS - 1));
               for (int k = 0; k < bfmb_pkg::MAX_SLOTS; k++) begin
                  rsp_freq_in[k] = slots_in[k];
                  slots_in[k]    = '0;
               end
               slot_in = '0;
               grp_in  = grp_ff + GRP_W'(1);
            end else begin
               slot_in = slot_ff + 3'd1;
            end
            if (idx_ff == SYM_AW'(SYMBOLS - 1)) begin
               // drop the histogram for the next text
               vld_in   = '0;
               seen_in  = '0;
               state_in = bfmb_pkg::ST_IDLE;
            end else begin
               idx_in   = idx_ff + SYM_AW'(1);
               state_in = bfmb_pkg::ST_EM_RD;
            end
         end
         default: state_in = bfmb_pkg::ST_IDLE;
      endcase

      if (state_ff == bfmb_pkg::ST_SCL_MUL && seen_ff != '0) begin
         div_req.start    = 1'b1;
         div_req.dividend = prod_in;
      end

      if (commit) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = scaled;
         vld_in[idx_ff] = 1'b1;
         sum_in = sum_ff + SUM_W'(scaled);
         if (scaled > top_val_ff) begin
            top_val_in = scaled;
            top_idx_in = idx_ff;
         end
         if (idx_ff == SYM_AW'(SYMBOLS - 1)) begin
            state_in = bfmb_pkg::ST_FIX;
         end else begin
            idx_in   = idx_ff + SYM_AW'(1);
            state_in = bfmb_pkg::ST_SCL_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfmb_pkg::ST_IDLE;
         vld_ff        <= '0;
         seen_ff       <= '0;
         total_ff      <= bfmb_pkg::TARGET_TOTAL_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vld_ff        <= vld_in;
         seen_ff       <= seen_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      top_val_ff  <= top_val_in;
      top_idx_ff  <= top_idx_in;
      prod_ff     <= prod_in;
      slot_ff     <= slot_in;
      grp_ff      <= grp_in;
      rsp_grp_ff  <= rsp_grp_in;
      rsp_last_ff <= rsp_last_in;
      for (int k = 0; k < bfmb_pkg::MAX_SLOTS; k++) begin
         slots_ff[k]    <= slots_in[k];
         rsp_freq_ff[k] <= rsp_freq_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign busy            = (state_ff != bfmb_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_group_index = rsp_grp_ff;
   assign rsp_freq_a      = rsp_freq_ff[0];
   assign rsp_freq_b      = rsp_freq_ff[1];
   assign rsp_freq_c      = rsp_freq_ff[2];
   assign rsp_freq_d      = rsp_freq_ff[3];
   assign rsp_freq_e      = rsp_freq_ff[4];
   assign rsp_freq_f      = rsp_freq_ff[5];
   assign rsp_freq_g      = rsp_freq_ff[6];
   assign rsp_freq_h      = rsp_freq_ff[7];
   assign rsp_last_group  = rsp_last_ff;
   assign prdata          = (paddr == bfmb_pkg::ADDR_TARGET_TOTAL) ? total_ff : '0;
   assign pready          = 1'b1;

endmodule

// ===== sim/bfmb_freq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_freq_checker
// Watches the byte, table and register channels of the frequency model
// builder. It keeps its own histogram, builds the scaled table on every
// last byte, queues the 32 group words, and compares each strobed group
// field by field.
// ----------------------------------------------------------------------------
module bfmb_freq_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   input  logic                            rsp_strobe,
   input  logic [bfmb_pkg::GRP_OUT_W-1:0]  rsp_group_index,
   input  logic [31:0]                     rsp_freq_a,
   input  logic [31:0]                     rsp_freq_b,
   input  logic [31:0]                     rsp_freq_c,
   input  logic [31:0]                     rsp_freq_d,
   input  logic [31:0]                     rsp_freq_e,
   input  logic [31:0]                     rsp_freq_f,
   input  logic [31:0]                     rsp_freq_g,
   input  logic [31:0]                     rsp_freq_h,
   input  logic                            rsp_last_group,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bfmb_pkg::CSR_AW-1:0]     paddr,
   input  logic [31:0]                     pwdata,
   input  logic                            pready,
   output int                              mismatches,
   output int                              groups_pending
);

   localparam int NSYM = bfmb_pkg::SYMBOLS_DEF;
   localparam int NGRP = NSYM / bfmb_pkg::FREQS_DEF;

   typedef struct packed {
      logic [bfmb_pkg::GRP_OUT_W-1:0] grp;
      logic [7:0][31:0]               freqs;
      logic                           last;
   } group_word_type;

   group_word_type expected_groups[$];
   logic [31:0]    bin_count[NSYM];
   logic [31:0]    byte_total;
   logic [31:0]    target_total;

   assign groups_pending = expected_groups.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic clear_histogram();
      for (int i = 0; i < NSYM; i++) bin_count[i] = '0;
      byte_total = '0;
   endtask

   // scale every bin to the target, fold the rounding error into the
   // first largest bin, and queue the table as group words
   task automatic queue_scaled_table();
      logic [31:0]    scaled[NSYM];
      logic [63:0]    prod;
      logic [63:0]    sum;
      int             top;
      group_word_type gw;
      sum = '0;
      top = 0;
      for (int i = 0; i < NSYM; i++) begin
         prod = '0;
         if (byte_total != 0)
            prod = (64'(bin_count[i]) * 64'(target_total)) / 64'(byte_total);
         scaled[i] = prod[31:0];
         sum += 64'(scaled[i]);
         if (scaled[i] > scaled[top]) top = i;
      end
      if (sum > 64'(target_total))
         scaled[top] = scaled[top] - 32'(sum - 64'(target_total));
      else if (sum < 64'(target_total))
         scaled[top] = scaled[top] + 32'(64'(target_total) - sum);
      for (int g = 0; g < NGRP; g++) begin
         gw.grp = bfmb_pkg::GRP_OUT_W'(g);
         for (int k = 0; k < 8; k++) gw.freqs[k] = scaled[g*8 + k];
         gw.last = (g == NGRP - 1);
         expected_groups.push_back(gw);
      end
   endtask

   always @(posedge clock) begin
      group_word_type   want;
      logic [7:0][31:0] got_f;
      if (reset) begin
         mismatches = 0;
         clear_histogram();
         target_total = bfmb_pkg::TARGET_TOTAL_RST;
         expected_groups.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == bfmb_pkg::ADDR_TARGET_TOTAL)
            target_total = pwdata;
         if (rsp_strobe) begin
            if (expected_groups.size() == 0) begin
               report_mismatch("group word with none queued, group_index",
                               32'(rsp_group_index), 32'(0));
            end else begin
               want = expected_groups.pop_front();
               got_f = {rsp_freq_h, rsp_freq_g, rsp_freq_f, rsp_freq_e,
                        rsp_freq_d, rsp_freq_c, rsp_freq_b, rsp_freq_a};
               if (rsp_group_index !== want.grp)
                  report_mismatch("group_index", 32'(rsp_group_index), 32'(want.grp));
               for (int k = 0; k < 8; k++)
                  if (got_f[k] !== want.freqs[k])
                     report_mismatch($sformatf("freq slot %0d of group %0d", k, want.grp),
                                     got_f[k], want.freqs[k]);
               if (rsp_last_group !== want.last)
                  report_mismatch("last_group", 32'(rsp_last_group), 32'(want.last));
            end
         end
         if (start && !busy) begin
            if (bin_count[req_data_byte] != '1) bin_count[req_data_byte]++;
            if (byte_total != '1) byte_total++;
            if (req_last_byte) begin
               queue_scaled_table();
               clear_histogram();
            end
         end
      end
   end

endmodule

// ===== sim/tb_byte_frequency_model_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_frequency_model_builder_core
// Feeds byte streams of varied skew and length through the model builder
// under several target totals and idle patterns; the checker predicts and
// compares every emitted table.
// ----------------------------------------------------------------------------
module tb_byte_frequency_model_builder_core;

   // every byte may close a text and cost a full scaling pass
   localparam longint CYCLE_LIMIT = 50000000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [7:0]                      req_data_byte = '0;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_strobe;
   logic [bfmb_pkg::GRP_OUT_W-1:0]  rsp_group_index;
   logic [31:0]                     rsp_freq_a, rsp_freq_b, rsp_freq_c, rsp_freq_d;
   logic [31:0]                     rsp_freq_e, rsp_freq_f, rsp_freq_g, rsp_freq_h;
   logic                            rsp_last_group;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [bfmb_pkg::CSR_AW-1:0]     paddr = '0;
   logic [31:0]                     pwdata = '0;
   logic [31:0]                     prdata;
   logic                            pready;
   int                              mismatches;
   int                              groups_pending;
   int                              idle_pct = 0;
   longint                          cycle_count = 0;

   always #5 clock = ~clock;

   byte_frequency_model_builder_core DUT (
      .clock, .reset, .start, .busy, .req_data_byte, .req_last_byte,
      .rsp_strobe, .rsp_group_index, .rsp_freq_a, .rsp_freq_b, .rsp_freq_c,
      .rsp_freq_d, .rsp_freq_e, .rsp_freq_f, .rsp_freq_g, .rsp_freq_h,
      .rsp_last_group, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bfmb_freq_checker u_checker (
      .clock, .reset, .start, .busy, .req_data_byte, .req_last_byte,
      .rsp_strobe, .rsp_group_index, .rsp_freq_a, .rsp_freq_b, .rsp_freq_c,
      .rsp_freq_d, .rsp_freq_e, .rsp_freq_f, .rsp_freq_g, .rsp_freq_h,
      .rsp_last_group, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatches, .groups_pending
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // hold start across back-to-back bytes; drop it only for an idle gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      start <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data_byte <= 8'($urandom);
         req_last_byte <= 1'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // settle: every group out, then a margin for the tail of the readout
   task automatic drain_tables();
      start <= 1'b0;
      @(posedge clock);
      while (groups_pending != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_target(input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= bfmb_pkg::ADDR_TARGET_TOTAL;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // one text: mostly a few hot symbols, sometimes spread over all bytes
   task automatic send_text(input int len);
      logic [7:0] hot[4];
      bit         spread;
      spread = ($urandom_range(2) == 0);
      for (int i = 0; i < 4; i++) hot[i] = 8'($urandom);
      for (int i = 0; i < len; i++)
         send_byte(spread ? 8'($urandom) : hot[$urandom_range(3)], i == len - 1);
   endtask

   task automatic random_phase(input int pct, input int n_bytes);
      int left;
      int len;
      idle_pct = pct;
      left = n_bytes;
      while (left > 0) begin
         len = $urandom_range(1, 60);
         if (len > left) len = left;
         send_text(len);
         left -= len;
      end
      drain_tables();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset total, single-byte text, extreme symbols, ties
      send_byte(8'd0, 1'b1);
      send_byte(8'd255, 1'b0);
      send_byte(8'd0, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h55, 1'b1);
      drain_tables();
      write_target(32'd1);
      send_byte(8'd7, 1'b0);
      send_byte(8'd200, 1'b0);
      send_byte(8'd7, 1'b1);
      send_byte(8'd255, 1'b1);
      drain_tables();
      write_target(32'd1000);
      for (int i = 0; i < 7; i++) send_byte(8'(i * 37), i == 6);
      drain_tables();

      write_target(32'hFFFF_FFFF);
      random_phase(31, 160);
      write_target(32'd4096);
      random_phase(74, 160);
      write_target($urandom_range(1, 32'hFFFF_FFFF));
      random_phase(0, 160);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
